// ----- rtl/psrf_pkg.sv -----
`timescale 1ns / 1ps
// Package for the per-source packet rate filter: payload structs, the beat
// that walks the cell chain, outcome codes and a shared helper. No dependencies.
package psrf_pkg;

   localparam int TABLE_ENTRIES = 1024;

   localparam logic [13:0] ETH_HEADER_BYTES = 14'd14;
   localparam logic [13:0] IPV4_MIN_BYTES   = 14'd34;
   localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
   localparam logic [31:0] THRESHOLD_RESET  = 32'd250;

   typedef enum logic [1:0] {
      OUTCOME_NOT_COUNTED = 2'd0,
      OUTCOME_TABLE_FULL  = 2'd1,
      OUTCOME_UNDER       = 2'd2,
      OUTCOME_OVER        = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [13:0] packet_length;
      logic [15:0] ether_type;
      logic [31:0] source_ip;
   } req_type;

   typedef struct packed {
      logic        drop;
      outcome_type outcome;
      logic [31:0] source_count;
      logic [31:0] seen_total;
      logic [31:0] dropped_total;
      logic [31:0] passed_total;
   } rsp_type;

   // One packet on its way down the table
   typedef struct packed {
      logic        valid;
      logic        counted;
      logic        found;
      logic [31:0] key;
      logic [31:0] count;
   } beat_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] value);
      return (value == 32'hFFFF_FFFF) ? value : value + 32'd1;
   endfunction

endpackage

// ----- rtl/per_source_packet_rate_filter_unit.sv -----
`timescale 1ns / 1ps
// Top level of the per-source packet rate filter: a chain of table cells
// followed by the verdict stage. Depends on psrf_pkg, psrf_cell, psrf_tally.
//
//   port group   direction  handshake          payload
//   req_         in         req_valid/stall    psrf_pkg::req_type
//   rsp_         out        rsp_valid/stall    psrf_pkg::rsp_type
//   csr_         in         csr_wr_en          drop threshold, 32 bits
//
// A beat passes through the beat register of every table cell, then the
// verdict register. Lockstep: one beat enters per cycle unless stalled.
// Reset clears every entry's valid bit and the totals, threshold back to 250.
// A stall on a valid rsp_ freezes the chain and is passed back as req_stall.
module per_source_packet_rate_filter_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  psrf_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output psrf_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   logic                                threshold_ff;
   logic [31:0]                         threshold_val_ff;
   logic                                advance;
   psrf_pkg::beat_type                  head_beat;
   psrf_pkg::beat_type                  beat_w [0:psrf_pkg::TABLE_ENTRIES];
   logic [psrf_pkg::TABLE_ENTRIES-1:0]  cell_valid_w;

   // threshold_ff marks the register as written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff     <= 1'b0;
         threshold_val_ff <= psrf_pkg::THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         threshold_ff     <= 1'b1;
         threshold_val_ff <= csr_wr_data;
      end
   end

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      head_beat.valid   = req_valid;
      head_beat.counted = (req_payload.packet_length >= psrf_pkg::ETH_HEADER_BYTES) &&
                          (req_payload.ether_type == psrf_pkg::ETHERTYPE_IPV4) &&
                          (req_payload.packet_length >= psrf_pkg::IPV4_MIN_BYTES);
      head_beat.found   = 1'b0;
      head_beat.key     = req_payload.source_ip;
      head_beat.count   = 32'd0;
   end

   assign beat_w[0] = head_beat;

   for (genvar g = 0; g < psrf_pkg::TABLE_ENTRIES; g++) begin : g_cell
      psrf_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .beat_i        (beat_w[g]),
         .beat_o        (beat_w[g+1]),
         .entry_valid_o (cell_valid_w[g])
      );
   end

   psrf_tally u_tally (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .beat_i      (beat_w[psrf_pkg::TABLE_ENTRIES]),
      .threshold   (threshold_val_ff),
      .rsp_valid_o (rsp_valid),
      .rsp_o       (rsp_payload)
   );

`ifndef SYNTHESIS
   // entries fill from the head of the chain and are never freed
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (cell_valid_w & ~{cell_valid_w[psrf_pkg::TABLE_ENTRIES-2:0], 1'b1}) == '0)
      else $error("table entry valid with a free entry ahead of it");

   a_drop_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.drop == (rsp_payload.outcome == psrf_pkg::OUTCOME_OVER)))
      else $error("drop flag disagrees with outcome");

   a_uncounted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.outcome == psrf_pkg::OUTCOME_NOT_COUNTED ||
                    rsp_payload.outcome == psrf_pkg::OUTCOME_TABLE_FULL)
      |-> rsp_payload.source_count == 32'd0)
      else $error("source count set on a packet outside the table");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.outcome == psrf_pkg::OUTCOME_UNDER ||
                    rsp_payload.outcome == psrf_pkg::OUTCOME_OVER)
      |-> rsp_payload.source_count != 32'd0 && rsp_payload.seen_total != 32'd0)
      else $error("counted packet without a count");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !threshold_ff)
      else $error("response or threshold write survived reset");
`endif

endmodule

// ----- rtl/psrf_cell.sv -----
`timescale 1ns / 1ps
// One table entry of the filter: holds a source address and its count, and
// matches or claims for the beat passing through. Depends on psrf_pkg.
module psrf_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  psrf_pkg::beat_type beat_i,
   output psrf_pkg::beat_type beat_o,
   output logic               entry_valid_o
);

   logic               valid_ff;
   logic               valid_in;
   logic [31:0]        source_ff;
   logic [31:0]        source_in;
   logic [31:0]        count_ff;
   logic [31:0]        count_in;
   psrf_pkg::beat_type beat_ff;
   psrf_pkg::beat_type beat_in;
   logic               active;
   logic               hit;
   logic               claim;

   always_comb begin
      active    = beat_i.valid && beat_i.counted && !beat_i.found;
      hit       = active && valid_ff && (source_ff == beat_i.key);
      claim     = active && !valid_ff;
      valid_in  = valid_ff;
      source_in = source_ff;
      count_in  = count_ff;
      beat_in   = beat_i;
      if (hit) begin
         count_in      = psrf_pkg::sat_inc(count_ff);
         beat_in.found = 1'b1;
         beat_in.count = count_in;
      end
      // first free entry down the chain takes a new source
      if (claim) begin
         valid_in      = 1'b1;
         source_in     = beat_i.key;
         count_in      = 32'd1;
         beat_in.found = 1'b1;
         beat_in.count = 32'd1;
      end
   end

   // only the valid bits take reset; the data simply follows them
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         beat_ff.valid  <= 1'b0;
      end else if (advance) begin
         valid_ff       <= valid_in;
         source_ff      <= source_in;
         count_ff       <= count_in;
         beat_ff        <= beat_in;
      end
   end

   assign beat_o        = beat_ff;
   assign entry_valid_o = valid_ff;

endmodule

// ----- rtl/psrf_tally.sv -----
`timescale 1ns / 1ps
// Verdict stage at the end of the cell chain: threshold compare, saturating
// totals and the response register. Depends on psrf_pkg.
module psrf_tally (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  psrf_pkg::beat_type beat_i,
   input  logic [31:0]        threshold,
   output logic               rsp_valid_o,
   output psrf_pkg::rsp_type  rsp_o
);

   logic              rsp_valid_ff;
   psrf_pkg::rsp_type rsp_ff;
   psrf_pkg::rsp_type rsp_in;
   logic [31:0]       seen_ff;
   logic [31:0]       seen_in;
   logic [31:0]       dropped_ff;
   logic [31:0]       dropped_in;
   logic [31:0]       passed_ff;
   logic [31:0]       passed_in;

   always_comb begin
      seen_in    = seen_ff;
      dropped_in = dropped_ff;
      passed_in  = passed_ff;
      rsp_in.drop         = 1'b0;
      rsp_in.outcome      = psrf_pkg::OUTCOME_NOT_COUNTED;
      rsp_in.source_count = 32'd0;
      if (beat_i.counted) begin
         seen_in = psrf_pkg::sat_inc(seen_ff);
         if (!beat_i.found) begin
            rsp_in.outcome = psrf_pkg::OUTCOME_TABLE_FULL;
         end else if (beat_i.count >= threshold) begin
            dropped_in          = psrf_pkg::sat_inc(dropped_ff);
            rsp_in.drop         = 1'b1;
            rsp_in.outcome      = psrf_pkg::OUTCOME_OVER;
            rsp_in.source_count = beat_i.count;
         end else begin
            passed_in           = psrf_pkg::sat_inc(passed_ff);
            rsp_in.outcome      = psrf_pkg::OUTCOME_UNDER;
            rsp_in.source_count = beat_i.count;
         end
      end
      rsp_in.seen_total    = seen_in;
      rsp_in.dropped_total = dropped_in;
      rsp_in.passed_total  = passed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seen_ff      <= 32'd0;
         dropped_ff   <= 32'd0;
         passed_ff    <= 32'd0;
      end else if (advance) begin
         rsp_valid_ff <= beat_i.valid;
         if (beat_i.valid) begin
            seen_ff    <= seen_in;
            dropped_ff <= dropped_in;
            passed_ff  <= passed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && beat_i.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid_o = rsp_valid_ff;
   assign rsp_o       = rsp_ff;

endmodule
